### rtl/ost_pkg.sv
// Shared types and constants for the ordered stream table.
`timescale 1ns / 1ps

package ost_pkg;

    localparam int KEY_W   = 32;
    localparam int MODE_W  = 8;
    // One stored entry: {closed, mode, key}.
    localparam int ENTRY_W = KEY_W + MODE_W + 1;
    localparam int DEPTH_DEF = 16;

    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 4;
    localparam int REMOVED_W = 5;
    localparam int COUNT_W   = 5;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_MARK  = 2'd1,
        OP_CLEAN = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    scan_begin;   // latch the key, reset counters, read entry 0
        logic    scan_next;    // advance to the next entry
        logic    mark_hit;     // set the closed flag of the current entry
        logic    pack_step;    // keep or drop the current entry
        logic    pack_end;     // commit the compacted entry count
        logic    put;          // append a new open entry
        logic    emit;         // register a result item
        logic    emit_slot;    // result carries the slot of the put
        logic    emit_removed; // result carries the removed count
        t_status status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic match;
        logic last;
    } t_dp_stat;

endpackage

### rtl/ordered_stream_table.sv
// Top level of the ordered stream table: controller plus datapath.
// Put, no-op, and mark or clean on an empty table give their result in the cycle after
// acceptance; a mark reads entries from slot 0 until a match or the last entry, and a clean
// walks all held entries. The entry RAM is read one entry per cycle during a scan.
// A new item is accepted only while idle; busy falls as the result is registered.
// Reset (synchronous, active low) empties the table; entry contents are not cleared.
`timescale 1ns / 1ps

module ordered_stream_table #(
    parameter int DEPTH = ost_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_opcode,
    input  logic [ost_pkg::KEY_W-1:0]     i_stream_key,
    input  logic [ost_pkg::MODE_W-1:0]    i_access_mode,
    output logic                          o_done,
    output logic [ost_pkg::STATUS_W-1:0]  o_status,
    output logic [ost_pkg::SLOT_W-1:0]    o_slot,
    output logic [ost_pkg::REMOVED_W-1:0] o_removed_count,
    output logic [ost_pkg::COUNT_W-1:0]   o_entry_count,
    output logic                          o_table_empty
);

    import ost_pkg::*;

    // The controller walks the table; the datapath holds the entries in a RAM
    // with one write and one registered read port. A scan issues one read per
    // cycle and processes the previous read's data in the same cycle, so a
    // clean writes each kept entry back at its compacted slot, which never
    // lies ahead of the slot being read.
    t_cmd     cmd;
    t_dp_stat stat;

    ost_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // Each result item is shown for one cycle with o_done high; the receiver
    // cannot stall it, and the next item may be started in that same cycle.
    ost_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_stream_key    (i_stream_key),
        .i_access_mode   (i_access_mode),
        .o_stat          (stat),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_removed_count (o_removed_count),
        .o_entry_count   (o_entry_count),
        .o_table_empty   (o_table_empty)
    );

endmodule

### rtl/ost_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ost_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ost_dp.sv
// Datapath of the ordered stream table: entry store, counters and result registers.
`timescale 1ns / 1ps

module ost_dp #(
    parameter int DEPTH = ost_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ost_pkg::t_cmd               i_cmd,
    input  logic [ost_pkg::KEY_W-1:0]   i_stream_key,
    input  logic [ost_pkg::MODE_W-1:0]  i_access_mode,
    output ost_pkg::t_dp_stat           o_stat,
    output logic                        o_done,
    output logic [ost_pkg::STATUS_W-1:0]  o_status,
    output logic [ost_pkg::SLOT_W-1:0]    o_slot,
    output logic [ost_pkg::REMOVED_W-1:0] o_removed_count,
    output logic [ost_pkg::COUNT_W-1:0]   o_entry_count,
    output logic                          o_table_empty
);

    import ost_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]      r_occ, n_occ;
    logic [KEY_W-1:0]   r_key;
    logic [CW-1:0]      r_nxt;
    logic [IW-1:0]      r_cur;
    logic [CW-1:0]      r_keep, n_keep;
    logic [CW-1:0]      r_rem, n_rem;

    logic               r_done;
    t_status            r_status;
    logic [SLOT_W-1:0]    r_slot;
    logic [REMOVED_W-1:0] r_removed;
    logic [COUNT_W-1:0]   r_count;
    logic                 r_empty;

    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [IW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    logic [CW+4:0]      occ_ext, nocc_ext, rem_ext;
    logic               cur_closed;

    ost_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign cur_closed = rd_data[ENTRY_W-1];
    assign n_keep     = cur_closed ? r_keep : r_keep + CW'(1);
    assign n_rem      = cur_closed ? r_rem + CW'(1) : r_rem;
    assign rd_addr    = i_cmd.scan_begin ? '0 : r_nxt[IW-1:0];

    assign o_stat.empty  = (r_occ == '0);
    assign o_stat.full   = (r_occ == CW'(DEPTH));
    assign o_stat.match  = (rd_data[KEY_W-1:0] == r_key);
    assign o_stat.last   = (r_nxt == r_occ);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cur;
        wr_data = rd_data;
        n_occ   = r_occ;
        if (i_cmd.put) begin
            wr_en   = 1'b1;
            wr_addr = r_occ[IW-1:0];
            wr_data = {1'b0, i_access_mode, i_stream_key};
            n_occ   = r_occ + CW'(1);
        end else if (i_cmd.mark_hit) begin
            wr_en   = 1'b1;
            wr_addr = r_cur;
            wr_data = {1'b1, rd_data[ENTRY_W-2:0]};
        end else if (i_cmd.pack_step) begin
            wr_en   = !cur_closed;
            wr_addr = r_keep[IW-1:0];
            wr_data = {1'b0, rd_data[ENTRY_W-2:0]};
        end
        if (i_cmd.pack_end) begin
            n_occ = n_keep;
        end
    end

    assign occ_ext  = {5'b0, r_occ};
    assign nocc_ext = {5'b0, n_occ};
    assign rem_ext  = {5'b0, n_rem};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_done <= 1'b0;
            r_nxt  <= '0;
            r_cur  <= '0;
            r_keep <= '0;
            r_rem  <= '0;
        end else begin
            r_occ  <= n_occ;
            r_done <= i_cmd.emit;
            if (i_cmd.scan_begin) begin
                r_key  <= i_stream_key;
                r_cur  <= '0;
                r_nxt  <= CW'(1);
                r_keep <= '0;
                r_rem  <= '0;
            end else begin
                if (i_cmd.scan_next) begin
                    r_cur <= r_nxt[IW-1:0];
                    r_nxt <= r_nxt + CW'(1);
                end
                if (i_cmd.pack_step) begin
                    r_keep <= n_keep;
                    r_rem  <= n_rem;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status  <= i_cmd.status;
            r_slot    <= i_cmd.emit_slot ? occ_ext[SLOT_W-1:0] : '0;
            r_removed <= i_cmd.emit_removed ? rem_ext[REMOVED_W-1:0] : '0;
            r_count   <= nocc_ext[COUNT_W-1:0];
            r_empty   <= (n_occ == '0);
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_slot          = r_slot;
    assign o_removed_count = r_removed;
    assign o_entry_count   = r_count;
    assign o_table_empty   = r_empty;

endmodule

### rtl/ost_ctrl.sv
// Controller of the ordered stream table: sequences put, mark and clean.
`timescale 1ns / 1ps

module ost_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_opcode,
    input  ost_pkg::t_dp_stat  i_stat,
    output ost_pkg::t_cmd      o_cmd,
    output logic               o_busy
);

    import ost_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PACK
    } t_state;

    t_state  r_state, n_state;
    t_opcode op;

    assign op = t_opcode'(i_opcode);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (op)
                        OP_PUT: begin
                            o_cmd.emit = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.status = ST_FULL;
                            end else begin
                                o_cmd.put       = 1'b1;
                                o_cmd.emit_slot = 1'b1;
                            end
                        end
                        OP_MARK: begin
                            if (i_stat.empty) begin
                                o_cmd.emit   = 1'b1;
                                o_cmd.status = ST_NOT_FOUND;
                            end else begin
                                o_cmd.scan_begin = 1'b1;
                                n_state          = S_SCAN;
                            end
                        end
                        OP_CLEAN: begin
                            if (i_stat.empty) begin
                                o_cmd.emit = 1'b1;
                            end else begin
                                o_cmd.scan_begin = 1'b1;
                                n_state          = S_PACK;
                            end
                        end
                        default: begin
                            o_cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (i_stat.match) begin
                    o_cmd.mark_hit = 1'b1;
                    o_cmd.emit     = 1'b1;
                    n_state        = S_IDLE;
                end else if (i_stat.last) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_NOT_FOUND;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_PACK: begin
                o_cmd.pack_step = 1'b1;
                if (i_stat.last) begin
                    o_cmd.pack_end     = 1'b1;
                    o_cmd.emit         = 1'b1;
                    o_cmd.emit_removed = 1'b1;
                    n_state            = S_IDLE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
